// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the PPM frame decoder.
// Included by rcppm_core, which checks its own state; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) \
    else $error("assertion failed");

// Check that a condition in one cycle implies another in the next.
`define ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rcppm_pkg.sv =====
// Shared types and constants of the PPM frame decoder.
// Used by rcppm_core and rc_ppm_frame_decoder; depends on nothing.
package rcppm_pkg;

  localparam int CHANNELS = 9;
  localparam int IDX_W    = $clog2(CHANNELS);
  localparam int CNT_W    = $clog2(CHANNELS + 2);
  localparam int CH_W     = 4;
  localparam int TIME_W   = 16;
  localparam int MASK_W   = 8;
  localparam int OP_W     = 3;

  localparam logic [TIME_W-1:0] SYNC_MIN_RESET = 16'd3000;
  localparam logic [TIME_W-1:0] NEUTRAL_RESET  = 16'd1500;
  localparam logic [MASK_W-1:0] FLAGS_ALL      = 8'hFF;

  localparam logic [0:0] REG_SYNC_MIN = 1'd0;
  localparam logic [0:0] REG_NEUTRAL  = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_EDGE    = 3'd0,
    OP_READ    = 3'd1,
    OP_CHECK   = 3'd2,
    OP_SUSPEND = 3'd3,
    OP_RESUME  = 3'd4
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] edge_time_us;
    logic [CH_W-1:0]   channel;
    logic [MASK_W-1:0] client_mask;
  } item_t;

  typedef struct packed {
    logic              sync_seen;
    logic [TIME_W-1:0] period_us;
    logic [CH_W-1:0]   channel_count;
    logic [TIME_W-1:0] pulse_width;
  } result_t;

endpackage

// ===== rtl/rc_ppm_frame_decoder.sv =====
// RC PPM frame decoder top level: configuration registers, stream ports,
// result register. Depends on rcppm_pkg and rcppm_core.
//
// Takes one word per cycle and returns exactly one result word for each,
// registered on acceptance. Each word is handled in a single pass through
// rcppm_core against the decoder state; the result register frees s_tready
// whenever it is empty or being drained, so throughput is one word per clock
// and a stall on the master side holds the input only once the result
// register is full. Op 0 is a rising edge whose 16-bit microsecond time gives
// the gap to the previous edge; op 1 reads a one-based channel width, op 2
// tests and clears sync flags by client mask, op 3 suspends, op 4 resumes.
// Configuration: index 0 sync threshold (reset 3000), index 1 neutral width
// (reset 1500); write only while idle.
module rc_ppm_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // edge_time_us[15:0], channel[19:16], client_mask[27:20]
  input  logic [2:0]  s_tuser,   // op[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // pulse_width[15:0], channel_count[19:16],
                                 // period_us[35:20], sync_seen[36]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [rcppm_pkg::TIME_W-1:0] sync_min_us;
  logic [rcppm_pkg::TIME_W-1:0] neutral_width;
  rcppm_pkg::item_t             item;
  rcppm_pkg::result_t           result;
  rcppm_pkg::result_t           result_q;
  logic                         take;

  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  assign item.op           = s_tuser;
  assign item.edge_time_us = s_tdata[15:0];
  assign item.channel      = s_tdata[19:16];
  assign item.client_mask  = s_tdata[27:20];

  rcppm_core u_core (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .item          (item),
    .sync_min_us   (sync_min_us),
    .neutral_width (neutral_width),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_min_us   <= rcppm_pkg::SYNC_MIN_RESET;
      neutral_width <= rcppm_pkg::NEUTRAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcppm_pkg::REG_SYNC_MIN: sync_min_us   <= cfg_data;
        rcppm_pkg::REG_NEUTRAL:  neutral_width <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_q <= result;
    end
  end

  assign m_tdata = {3'b000, result_q};

endmodule

// ===== rtl/rcppm_core.sv =====
// Decoder state and the combinational next-state update for one accepted word.
// Depends on rcppm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcppm_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  rcppm_pkg::item_t              item,
  input  logic [rcppm_pkg::TIME_W-1:0]  sync_min_us,
  input  logic [rcppm_pkg::TIME_W-1:0]  neutral_width,
  output rcppm_pkg::result_t            result
);

  logic [rcppm_pkg::TIME_W-1:0] prev_edge_time, prev_edge_time_next;
  logic [rcppm_pkg::CNT_W-1:0]  chan_index, chan_index_next;
  logic [rcppm_pkg::CNT_W-1:0]  frame_channels, frame_channels_next;
  logic [rcppm_pkg::TIME_W-1:0] chan_widths [rcppm_pkg::CHANNELS];
  logic [rcppm_pkg::MASK_W-1:0] sync_flags, sync_flags_next;
  logic                         period_phase, period_phase_next;
  logic [rcppm_pkg::TIME_W-1:0] period_start, period_start_next;
  logic [rcppm_pkg::TIME_W-1:0] frame_period, frame_period_next;
  logic [rcppm_pkg::TIME_W-1:0] last_gap, last_gap_next;

  logic [rcppm_pkg::TIME_W-1:0] gap;
  logic                         is_sync;
  logic                         wr_en;
  logic [rcppm_pkg::IDX_W-1:0]  rd_idx;
  logic                         rd_hit;
  logic [rcppm_pkg::TIME_W-1:0] rd_width;
  logic                         seen;
  rcppm_pkg::op_t               op;

  assign op      = rcppm_pkg::op_t'(item.op);
  assign gap     = item.edge_time_us - prev_edge_time;
  assign is_sync = gap >= sync_min_us;
  assign seen    = (sync_flags & item.client_mask) != '0;
  assign rd_idx  = rcppm_pkg::IDX_W'(item.channel - 4'd1);
  assign rd_hit  = (item.channel != '0)
                   && (item.channel <= rcppm_pkg::CH_W'(frame_channels))
                   && (item.channel <= rcppm_pkg::CH_W'(rcppm_pkg::CHANNELS));
  assign rd_width = rd_hit ? chan_widths[rd_idx] : neutral_width;

  always_comb begin
    prev_edge_time_next = prev_edge_time;
    chan_index_next     = chan_index;
    frame_channels_next = frame_channels;
    sync_flags_next     = sync_flags;
    period_phase_next   = period_phase;
    period_start_next   = period_start;
    frame_period_next   = frame_period;
    last_gap_next       = last_gap;
    wr_en               = 1'b0;
    result.pulse_width  = last_gap;
    result.sync_seen    = 1'b0;
    unique case (op)
      rcppm_pkg::OP_EDGE: begin
        prev_edge_time_next = item.edge_time_us;
        last_gap_next       = gap;
        result.pulse_width  = gap;
        if (is_sync) begin
          frame_channels_next = (chan_index > rcppm_pkg::CNT_W'(rcppm_pkg::CHANNELS))
                                ? rcppm_pkg::CNT_W'(rcppm_pkg::CHANNELS) : chan_index;
          chan_index_next     = '0;
          sync_flags_next     = rcppm_pkg::FLAGS_ALL;
          period_phase_next   = ~period_phase;
          if (!period_phase) begin
            period_start_next = item.edge_time_us;
          end else begin
            frame_period_next = item.edge_time_us - period_start;
          end
        end else if (chan_index < rcppm_pkg::CNT_W'(rcppm_pkg::CHANNELS)) begin
          wr_en           = 1'b1;
          chan_index_next = chan_index + 1'b1;
        end
      end
      rcppm_pkg::OP_READ: begin
        result.pulse_width = rd_width;
      end
      rcppm_pkg::OP_CHECK: begin
        result.sync_seen = seen;
        sync_flags_next  = sync_flags & ~item.client_mask;
      end
      rcppm_pkg::OP_SUSPEND: begin
        chan_index_next = rcppm_pkg::CNT_W'(rcppm_pkg::CHANNELS + 1);
      end
      rcppm_pkg::OP_RESUME: begin
        prev_edge_time_next = item.edge_time_us;
      end
      default: begin
      end
    endcase
    result.channel_count = rcppm_pkg::CH_W'(frame_channels_next);
    result.period_us     = frame_period_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_edge_time <= '0;
      chan_index     <= rcppm_pkg::CNT_W'(rcppm_pkg::CHANNELS + 1);
      frame_channels <= '0;
      sync_flags     <= '0;
      period_phase   <= 1'b0;
      period_start   <= '0;
      frame_period   <= '0;
      last_gap       <= '0;
      for (int i = 0; i < rcppm_pkg::CHANNELS; i++) begin
        chan_widths[i] <= rcppm_pkg::NEUTRAL_RESET;
      end
    end else if (take) begin
      prev_edge_time <= prev_edge_time_next;
      chan_index     <= chan_index_next;
      frame_channels <= frame_channels_next;
      sync_flags     <= sync_flags_next;
      period_phase   <= period_phase_next;
      period_start   <= period_start_next;
      frame_period   <= frame_period_next;
      last_gap       <= last_gap_next;
      if (wr_en) begin
        chan_widths[chan_index[rcppm_pkg::IDX_W-1:0]] <= gap;
      end
    end
  end

  `ASSERT_ALWAYS(a_index_range, clk, rst,
    chan_index <= rcppm_pkg::CNT_W'(rcppm_pkg::CHANNELS + 1))
  `ASSERT_ALWAYS(a_count_range, clk, rst,
    frame_channels <= rcppm_pkg::CNT_W'(rcppm_pkg::CHANNELS))
  `ASSERT_NEXT(a_sync_sets_flags, clk, rst,
    take && op == rcppm_pkg::OP_EDGE && is_sync,
    sync_flags == rcppm_pkg::FLAGS_ALL && chan_index == '0)

endmodule

// ===== tb/sv/tb_rc_ppm_frame_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rc_ppm_frame_decoder: edge, read, sync-check and
// suspend/resume words against a built-in decoder model, under random idling.
// Depends on rcppm_pkg and the rc_ppm_frame_decoder RTL.
module tb_rc_ppm_frame_decoder;
  import rcppm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID   = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // edge_time_us[15:0], channel[19:16], client_mask[27:20]
  logic [2:0]  s_tuser = '0;   // op[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // pulse_width[15:0], channel_count[19:16],
                               // period_us[35:20], sync_seen[36]
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  rc_ppm_frame_decoder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // decoder model state
  logic [15:0] sync_min_cfg;
  logic [15:0] neutral_cfg;
  logic [15:0] prev_edge_us;
  int unsigned chan_idx;
  logic [3:0]  frame_chans;
  logic [15:0] width_mem [CHANNELS];
  logic [7:0]  sync_flags;
  logic        period_toggle;
  logic [15:0] period_origin;
  logic [15:0] period_val;
  logic [15:0] last_gap_us;

  item_t   pending_words[$];
  result_t expected_results[$];
  item_t   cur_word;
  logic    word_taken = 1'b0;
  int      words_queued = 0;
  int      mismatches = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  logic [15:0] t_cursor;

  function automatic result_t decode_word(item_t w);
    result_t r;
    logic [15:0] gap;
    r = '0;
    r.pulse_width = last_gap_us;
    case (w.op)
      OP_EDGE: begin
        gap = w.edge_time_us - prev_edge_us;
        prev_edge_us = w.edge_time_us;
        last_gap_us = gap;
        if (gap >= sync_min_cfg) begin
          frame_chans = (chan_idx > CHANNELS) ? 4'(CHANNELS) : 4'(chan_idx);
          chan_idx = 0;
          sync_flags = FLAGS_ALL;
          period_toggle = ~period_toggle;
          if (period_toggle)
            period_origin = w.edge_time_us;
          else
            period_val = w.edge_time_us - period_origin;
        end else if (chan_idx < CHANNELS) begin
          width_mem[chan_idx] = gap;
          chan_idx++;
        end
        r.pulse_width = gap;
      end
      OP_READ: begin
        if (w.channel >= 1 && w.channel <= frame_chans && w.channel <= CHANNELS)
          r.pulse_width = width_mem[w.channel - 1];
        else
          r.pulse_width = neutral_cfg;
      end
      OP_CHECK: begin
        r.sync_seen = |(sync_flags & w.client_mask);
        if (r.sync_seen) sync_flags = sync_flags & ~w.client_mask;
      end
      OP_SUSPEND: chan_idx = CHANNELS + 1;
      OP_RESUME:  prev_edge_us = w.edge_time_us;
      default: ;
    endcase
    r.channel_count = frame_chans;
    r.period_us = period_val;
    return r;
  endfunction

  function automatic void push_word(logic [2:0] op, logic [15:0] t, logic [3:0] ch,
                                    logic [7:0] mask);
    item_t w;
    w.op = op;
    w.edge_time_us = t;
    w.channel = ch;
    w.client_mask = mask;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("ERROR at %0t: %s", $time, what);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SYNC_MIN) sync_min_cfg = val;
    else neutral_cfg = val;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // frames with reads, checks, the odd suspend/resume, spare op or random-time edge between edges
  task automatic gen_traffic(input int n_words);
    int stop_at, n_ch, roll, lo, hi;
    logic [15:0] gap;
    stop_at = words_queued + n_words;
    while (words_queued < stop_at) begin
      hi = sync_min_cfg + 15000;
      if (hi > 65535 || $urandom_range(15) == 0) hi = 65535;
      gap = 16'($urandom_range(hi, sync_min_cfg));
      t_cursor = t_cursor + gap;
      push_word(OP_EDGE, t_cursor, 4'($urandom), 8'($urandom));
      n_ch = $urandom_range(12, 0);
      for (int i = 0; i < n_ch; i++) begin
        if (sync_min_cfg == 0 || $urandom_range(7) == 0) begin
          gap = (sync_min_cfg == 0) ? 16'($urandom) : 16'($urandom_range(sync_min_cfg - 1, 0));
        end else begin
          hi = (sync_min_cfg - 1 < 2200) ? sync_min_cfg - 1 : 2200;
          lo = (hi < 800) ? hi : 800;
          gap = 16'($urandom_range(hi, lo));
        end
        t_cursor = t_cursor + gap;
        push_word(OP_EDGE, t_cursor, 4'($urandom), 8'($urandom));
        if ($urandom_range(3) == 0) begin
          roll = $urandom_range(15);
          if (roll <= 6 || roll >= 14)
            push_word(OP_READ, 16'($urandom), 4'($urandom_range(15, 0)), 8'($urandom));
          else if (roll <= 9)
            push_word(OP_CHECK, 16'($urandom), 4'($urandom), 8'($urandom));
          else if (roll == 10)
            push_word(OP_SUSPEND, 16'($urandom), 4'($urandom), 8'($urandom));
          else if (roll == 11) begin
            t_cursor = t_cursor + 16'($urandom_range(6000));
            push_word(OP_RESUME, t_cursor, 4'($urandom), 8'($urandom));
          end else if (roll == 12)
            push_word(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), 16'($urandom),
                      4'($urandom), 8'($urandom));
          else begin
            t_cursor = 16'($urandom);
            push_word(OP_EDGE, t_cursor, 4'($urandom), 8'($urandom));
          end
        end
      end
    end
  endtask

  // driver: hold the word until taken, then advance or idle
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      word_taken = 1'b0;
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_word = pending_words.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, cur_word.client_mask, cur_word.channel, cur_word.edge_time_us};
        s_tuser <= cur_word.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // monitor: check the result side first, then record the accepted word
  always @(posedge clk) begin
    result_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[36:0]);
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.pulse_width !== want.pulse_width ||
              got.channel_count !== want.channel_count ||
              got.period_us !== want.period_us || got.sync_seen !== want.sync_seen)
            report_mismatch($sformatf(
              "width %h/%h count %h/%h period %h/%h seen %b/%b (exp/act)",
              want.pulse_width, got.pulse_width, want.channel_count, got.channel_count,
              want.period_us, got.period_us, want.sync_seen, got.sync_seen));
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(decode_word(cur_word));
        word_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] sync_val, neutral_val;
    sync_min_cfg = SYNC_MIN_RESET;
    neutral_cfg = NEUTRAL_RESET;
    prev_edge_us = '0;
    chan_idx = CHANNELS + 1;
    frame_chans = '0;
    foreach (width_mem[i]) width_mem[i] = NEUTRAL_RESET;
    sync_flags = '0;
    period_toggle = 1'b0;
    period_origin = '0;
    period_val = '0;
    last_gap_us = '0;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    push_word(OP_READ, 16'h0000, 4'd1, 8'h00);
    push_word(OP_CHECK, 16'h0000, 4'd0, 8'hFF);
    push_word(OP_EDGE, 16'd100, 4'd0, 8'h00);
    push_word(OP_EDGE, 16'd3100, 4'd0, 8'h00);
    push_word(OP_CHECK, 16'h0000, 4'd0, 8'h01);
    push_word(OP_CHECK, 16'h0000, 4'd0, 8'h01);
    push_word(OP_CHECK, 16'hFFFF, 4'hF, 8'h00);
    push_word(OP_EDGE, 16'd4100, 4'd0, 8'h00);
    push_word(OP_EDGE, 16'd7099, 4'd0, 8'h00);
    push_word(OP_EDGE, 16'd7099, 4'd0, 8'h00);
    push_word(OP_READ, 16'h0000, 4'd2, 8'h00);
    push_word(OP_READ, 16'h0000, 4'd0, 8'h00);
    push_word(OP_READ, 16'hFFFF, 4'd15, 8'hFF);
    push_word(OP_READ, 16'h0000, 4'd9, 8'h00);
    push_word(OP_SUSPEND, 16'h0000, 4'd0, 8'h00);
    push_word(OP_EDGE, 16'd8599, 4'd0, 8'h00);
    push_word(OP_EDGE, 16'hFFFF, 4'd0, 8'h00);
    push_word(OP_EDGE, 16'd1000, 4'd0, 8'h00);
    push_word(OP_RESUME, 16'hFFFF, 4'd0, 8'h00);
    push_word(OP_EDGE, 16'hFFFE, 4'd0, 8'h00);
    push_word(OP_READ, 16'h0000, 4'd1, 8'h00);
    push_word(OP_READ, 16'h0000, 4'd2, 8'h00);
    push_word(OP_CHECK, 16'h0000, 4'd0, 8'hFF);
    push_word(OP_SPARE_FIRST, 16'hFFFF, 4'hF, 8'hFF);
    push_word(OP_SPARE_MID, 16'h0000, 4'd0, 8'h00);
    push_word(OP_SPARE_LAST, 16'hA5A5, 4'h5, 8'h5A);
    t_cursor = 16'hFFFE;

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      case (ph)
        0: begin sync_val = 16'd3000;  neutral_val = 16'd1500;  end
        1: begin sync_val = 16'd0;     neutral_val = 16'd0;     end
        2: begin sync_val = 16'hFFFF;  neutral_val = 16'hFFFF;  end
        3: begin sync_val = 16'd2500;  neutral_val = 16'($urandom);  end
        4: begin
          sync_val = 16'($urandom_range(20000, 1000));
          neutral_val = 16'($urandom);
        end
        default: begin sync_val = 16'd3000; neutral_val = 16'd1200; end
      endcase
      write_reg(REG_SYNC_MIN, sync_val);
      write_reg(REG_NEUTRAL, neutral_val);
      gen_traffic(255);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
